>>> hdl/cps_pkg.sv
// shared types and constants for the companion power sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package cps_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned TIMER_W    = 24;
    localparam int unsigned SAMP_W     = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_CUT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOOT_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRACE           = 3'd4;

    // reset values
    localparam logic [SAMP_W-1:0]  RST_SAMPLE_INTERVAL = 16'd250;
    localparam logic [TIMER_W-1:0] RST_POWER_CUT       = 24'd2000;
    localparam logic [TIMER_W-1:0] RST_BOOT_LIMIT      = 24'd120000;
    localparam logic [TIMER_W-1:0] RST_ACK_TIMEOUT     = 24'd60000;
    localparam logic [TIMER_W-1:0] RST_GRACE           = 24'd60000;

    // outcome codes
    localparam logic [2:0] OC_NONE     = 3'd0;
    localparam logic [2:0] OC_OK       = 3'd1;
    localparam logic [2:0] OC_ALREADY  = 3'd2;
    localparam logic [2:0] OC_BOOT_TO  = 3'd3;
    localparam logic [2:0] OC_ACK_TO   = 3'd4;
    localparam logic [2:0] OC_GRACE_TO = 3'd5;

    // command codes
    localparam logic [1:0] REQ_TICK     = 2'd0;
    localparam logic [1:0] REQ_STARTUP  = 2'd1;
    localparam logic [1:0] REQ_SHUTDOWN = 2'd2;
    localparam logic [1:0] REQ_RESTART  = 2'd3;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_CUT   = 6'b000010,
        PH_BOOT  = 6'b000100,
        PH_ACK   = 6'b001000,
        PH_GRACE = 6'b010000,
        PH_RCUT  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [SAMP_W-1:0]  sample_interval;
        logic [TIMER_W-1:0] power_cut;
        logic [TIMER_W-1:0] boot_limit;
        logic [TIMER_W-1:0] ack_timeout;
        logic [TIMER_W-1:0] grace;
    } t_cfg;

    typedef struct packed {
        logic       power_on;
        logic       shutdown_drive;
        logic       busy;
        logic       done;
        logic [2:0] outcome;
    } t_seq_res;

    typedef struct packed {
        t_seq_res seq;
        logic     host_up;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/cps_cfg_regs.sv
// configuration register file of the power sequencer
// depends on cps_pkg
`default_nettype none

module cps_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [cps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [cps_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output cps_pkg::t_cfg                        o_cfg
);
    import cps_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_interval <= RST_SAMPLE_INTERVAL;
            r_cfg.power_cut       <= RST_POWER_CUT;
            r_cfg.boot_limit      <= RST_BOOT_LIMIT;
            r_cfg.ack_timeout     <= RST_ACK_TIMEOUT;
            r_cfg.grace           <= RST_GRACE;
        end else if (i_cfg_valid) begin
            // indexes beyond the list are dropped
            unique case (i_cfg_index)
                REG_SAMPLE_INTERVAL: r_cfg.sample_interval <= i_cfg_data[SAMP_W-1:0];
                REG_POWER_CUT:       r_cfg.power_cut       <= i_cfg_data;
                REG_BOOT_LIMIT:      r_cfg.boot_limit      <= i_cfg_data;
                REG_ACK_TIMEOUT:     r_cfg.ack_timeout     <= i_cfg_data;
                REG_GRACE:           r_cfg.grace           <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> hdl/cps_sampler.sv
// monitor pin sampler and host-up qualifier
// depends on cps_pkg
`default_nettype none

module cps_sampler #(
    parameter int unsigned SAMPLE_COUNT = 5
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic                        i_level,
    input  wire logic [cps_pkg::SAMP_W-1:0]  i_interval,
    output logic                             o_host_up
);
    import cps_pkg::*;

    logic [SAMP_W-1:0]       r_timer;
    logic [SAMP_W-1:0]       n_timer;
    logic [SAMPLE_COUNT-1:0] r_window;
    logic [SAMPLE_COUNT-1:0] n_window;
    logic [SAMP_W:0]         timer_inc;

    always_comb begin
        timer_inc = {1'b0, r_timer} + {{SAMP_W{1'b0}}, 1'b1};
        n_window  = r_window;
        if (timer_inc >= {1'b0, i_interval}) begin
            n_timer  = '0;
            n_window = SAMPLE_COUNT'({r_window, i_level});
        end else begin
            n_timer = timer_inc[SAMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer  <= '0;
            r_window <= '0;
        end else if (i_step) begin
            r_timer  <= n_timer;
            r_window <= n_window;
        end
    end

    // qualifier as seen by the item being processed
    assign o_host_up = &n_window;

endmodule

`default_nettype wire

>>> hdl/cps_sequencer.sv
// command sequencer: phase machine, wait timer, power and shutdown lines
// depends on cps_pkg
`default_nettype none

module cps_sequencer (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire logic [1:0]     i_req,
    input  wire logic           i_host_up,
    input  wire cps_pkg::t_cfg  i_cfg,
    output cps_pkg::t_seq_res   o_res
);
    import cps_pkg::*;

    t_phase             r_phase;
    t_phase             n_phase;
    logic [TIMER_W-1:0] r_timer;
    logic [TIMER_W-1:0] n_timer;
    logic               r_power;
    logic               n_power;
    logic               r_sd;
    logic               n_sd;
    logic               done;
    logic [2:0]         outcome;
    logic [TIMER_W-1:0] timer_inc;
    logic [TIMER_W-1:0] limit;
    logic               wait_over;

    always_comb begin
        timer_inc = r_timer + TIMER_W'(1);
        unique case (r_phase)
            PH_CUT, PH_RCUT: limit = i_cfg.power_cut;
            PH_BOOT:         limit = i_cfg.boot_limit;
            PH_ACK:          limit = i_cfg.ack_timeout;
            default:         limit = i_cfg.grace;
        endcase
        wait_over = timer_inc >= limit;
    end

    always_comb begin
        n_phase = r_phase;
        n_timer = r_timer;
        n_power = r_power;
        n_sd    = r_sd;
        done    = 1'b0;
        outcome = OC_NONE;
        unique case (r_phase)
            PH_IDLE: begin
                unique case (i_req)
                    REQ_STARTUP: begin
                        if (i_host_up) begin
                            n_power = 1'b1;
                            done    = 1'b1;
                            outcome = OC_ALREADY;
                        end else begin
                            n_power = 1'b0;
                            n_phase = PH_CUT;
                            n_timer = '0;
                        end
                    end
                    REQ_SHUTDOWN: begin
                        if (!i_host_up) begin
                            done    = 1'b1;
                            outcome = OC_ALREADY;
                        end else begin
                            n_sd    = 1'b1;
                            n_phase = PH_ACK;
                            n_timer = '0;
                        end
                    end
                    REQ_RESTART: begin
                        n_power = 1'b0;
                        n_phase = PH_RCUT;
                        n_timer = '0;
                    end
                    default: ;
                endcase
            end
            PH_CUT: begin
                n_timer = timer_inc;
                if (wait_over) begin
                    n_power = 1'b1;
                    n_phase = PH_BOOT;
                    n_timer = '0;
                end
            end
            PH_RCUT: begin
                n_timer = timer_inc;
                if (wait_over) begin
                    n_power = 1'b1;
                    n_phase = PH_IDLE;
                    n_timer = '0;
                    done    = 1'b1;
                    outcome = OC_OK;
                end
            end
            PH_BOOT: begin
                if (i_host_up) begin
                    n_phase = PH_IDLE;
                    n_timer = '0;
                    done    = 1'b1;
                    outcome = OC_OK;
                end else if (wait_over) begin
                    n_phase = PH_IDLE;
                    n_timer = '0;
                    done    = 1'b1;
                    outcome = OC_BOOT_TO;
                end else begin
                    n_timer = timer_inc;
                end
            end
            PH_ACK: begin
                if (!i_host_up) begin
                    n_sd    = 1'b0;
                    n_phase = PH_GRACE;
                    n_timer = '0;
                end else if (wait_over) begin
                    n_phase = PH_IDLE;
                    n_timer = '0;
                    done    = 1'b1;
                    outcome = OC_ACK_TO;
                end else begin
                    n_timer = timer_inc;
                end
            end
            PH_GRACE: begin
                n_timer = timer_inc;
                if (wait_over) begin
                    if (i_host_up) begin
                        outcome = OC_GRACE_TO;
                    end else begin
                        n_power = 1'b0;
                        outcome = OC_OK;
                    end
                    n_phase = PH_IDLE;
                    n_timer = '0;
                    done    = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_timer = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_timer <= '0;
            r_power <= 1'b0;
            r_sd    <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_power <= n_power;
            r_sd    <= n_sd;
        end
    end

    always_comb begin
        o_res.power_on       = n_power;
        o_res.shutdown_drive = n_sd;
        o_res.busy           = (n_phase != PH_IDLE);
        o_res.done           = done;
        o_res.outcome        = outcome;
    end

endmodule

`default_nettype wire

>>> hdl/companion_power_sequencer.sv
// top level of the companion power sequencer: input register, result skid buffer
// depends on cps_pkg, cps_cfg_regs, cps_sampler, cps_sequencer
`default_nettype none

// Power sequencer for a companion computer. Every input transfer is one time
// tick carrying an optional command (startup, shutdown, forced restart) and the
// level of the host-alive monitor pin; every tick gives exactly one result
// transfer with the power switch drive, the shutdown request line, busy, a
// one-tick done pulse with its outcome code, and the qualified host-up flag.
// The pin is sampled every sample_interval_ticks ticks into a window of
// SAMPLE_COUNT samples; the host counts as up while all of them are high.
// Commands arriving while a sequence runs, or on the tick it finishes, are
// dropped. Throughput is one tick per clock cycle while the result side does
// not stall: the tick is held in the input register, its state update (sampler
// and phase machine, one 24-bit increment and compare) is done from that
// register, and the result lands in the output register. A two-entry output
// buffer lets the block place one more result in its skid entry after the
// result side stalls. Configuration writes are always ready and are meant to
// be done while no tick is in flight.
module companion_power_sequencer #(
    parameter int unsigned SAMPLE_COUNT = 5
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // tick channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [1:0]                      i_req_type,
    input  wire logic                            i_monitor_level,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_power_on,
    output logic                                 o_shutdown_drive,
    output logic                                 o_busy_res,
    output logic                                 o_done_res,
    output logic [2:0]                           o_outcome,
    output logic                                 o_host_up,
    // configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [cps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [cps_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cps_pkg::*;

    t_cfg     cfg;
    t_seq_res seq_res;
    t_result  result;
    logic     host_up;

    // input register
    logic       r_in_valid;
    logic       n_in_valid;
    logic [1:0] r_req;
    logic       r_level;

    // output register and skid entry
    logic    r_out_valid;
    logic    n_out_valid;
    logic    r_sk_valid;
    logic    n_sk_valid;
    t_result r_out;
    t_result n_out;
    t_result r_sk;
    t_result n_sk;

    logic in_take;
    logic proc_go;
    logic out_take;

    assign o_cfg_ready = 1'b1;

    // the held tick moves on whenever the skid entry is free
    assign proc_go    = r_in_valid && !r_sk_valid;
    assign o_in_stall = r_in_valid && r_sk_valid;
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;

    cps_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cps_sampler #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_sampler (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (proc_go),
        .i_level    (r_level),
        .i_interval (cfg.sample_interval),
        .o_host_up  (host_up)
    );

    cps_sequencer u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (proc_go),
        .i_req     (r_req),
        .i_host_up (host_up),
        .i_cfg     (cfg),
        .o_res     (seq_res)
    );

    always_comb begin
        result.seq     = seq_res;
        result.host_up = host_up;
    end

    // input register control
    always_comb begin
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (proc_go) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    // result buffer: skid entry drains first, new results go to the free slot
    always_comb begin
        n_out_valid = r_out_valid;
        n_sk_valid  = r_sk_valid;
        n_out       = r_out;
        n_sk        = r_sk;
        if (r_sk_valid) begin
            if (out_take) begin
                n_out      = r_sk;
                n_sk_valid = 1'b0;
            end
        end else if (proc_go) begin
            if (!r_out_valid || out_take) begin
                n_out       = result;
                n_out_valid = 1'b1;
            end else begin
                n_sk       = result;
                n_sk_valid = 1'b1;
            end
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_sk_valid  <= n_sk_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req   <= i_req_type;
            r_level <= i_monitor_level;
        end
        r_out <= n_out;
        r_sk  <= n_sk;
    end

    assign o_out_valid      = r_out_valid;
    assign o_power_on       = r_out.seq.power_on;
    assign o_shutdown_drive = r_out.seq.shutdown_drive;
    assign o_busy_res       = r_out.seq.busy;
    assign o_done_res       = r_out.seq.done;
    assign o_outcome        = r_out.seq.outcome;
    assign o_host_up        = r_out.host_up;

endmodule

`default_nettype wire
